// ===== sv/fisr_pkg.sv =====
// Shared types, constants and helpers for the reciprocal square root pipeline.
package fisr_pkg;

    localparam logic [31:0] MAGIC_SEED = 32'h5F375A86;
    localparam logic [31:0] FP_HALF    = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;
    localparam logic [31:0] FP_QNAN    = 32'h7FC00000;
    localparam int unsigned NUM_STAGES = 16;
    localparam int unsigned SEED_TAPS  = 13;

    // Operand class carried ahead of normalization
    typedef enum logic [1:0] {
        KIND_NUM  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_INF  = 2'd2,
        KIND_NAN  = 2'd3
    } kind_t;

    // Unnormalized magnitude handed to the normalize/round unit:
    // value = mag * 2^(exp - 127 - 47) when the leading one sits at bit 47
    typedef struct packed {
        logic              sign;
        kind_t             kind;
        logic signed [10:0] exp;
        logic [47:0]       mag;
    } norm_in_t;

    // Count leading zeros of a 48-bit magnitude
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] cnt;
        logic       found;
        cnt   = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                cnt   = 6'(47 - i);
                found = 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== sv/fast_inverse_sqrt_float32_top.sv =====
// Usage notes:
// Streaming approximate reciprocal square root on binary32 raw bits.
// Slave side (s_tvalid/s_tready/s_tdata) takes one input value per beat;
// master side (m_tvalid/m_tready/m_tdata) delivers one result per beat.
// The seed comes from the integer magic-constant trick and is refined by
// one Newton-Raphson step built from four multipliers and one adder.
// Each multiplier takes 3 stages and the adder 4, all chained in order.
// Throughput is one beat per cycle while the receiver keeps m_tready high.
// The whole pipeline advances together: when the final result is held
// and m_tready is low, every stage freezes and s_tready drops; bubbles
// in flight keep their place, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// NaN results always leave as the canonical quiet NaN 0x7FC00000.
module fast_inverse_sqrt_float32_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result_bits
);
    import fisr_pkg::*;

    logic                  en;
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [31:0]           seed_next;
    logic [31:0]           y_dly_reg [SEED_TAPS];
    logic [31:0]           half_x;
    logic [31:0]           t1;
    logic [31:0]           t2;
    logic [31:0]           t3;
    logic [31:0]           r;

    // Advance the pipeline unless the held result is blocked
    assign en       = ~vld_reg[NUM_STAGES-1] | m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[NUM_STAGES-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Form the seed from the arithmetic shift and delay it to each use
    assign seed_next = MAGIC_SEED - {s_tdata[31], s_tdata[31:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_dly_reg[0] <= seed_next;
            for (int i = 1; i < SEED_TAPS; i++)
            begin
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
        end
    end

    fisr_fmul u_mul_half (
        .clk (clk), .en (en), .a (FP_HALF), .b (s_tdata), .result (half_x)
    );

    fisr_fmul u_mul_t1 (
        .clk (clk), .en (en), .a (half_x), .b (y_dly_reg[2]), .result (t1)
    );

    fisr_fmul u_mul_t2 (
        .clk (clk), .en (en), .a (t1), .b (y_dly_reg[5]), .result (t2)
    );

    fisr_fadd u_sub_t3 (
        .clk (clk), .en (en), .a (FP_THREE_HALVES), .b ({~t2[31], t2[30:0]}),
        .result (t3)
    );

    fisr_fmul u_mul_r (
        .clk (clk), .en (en), .a (y_dly_reg[12]), .b (t3), .result (r)
    );

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = r;

`ifndef SYNTHESIS
    a_stall_only_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_freeze_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_canonical_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0)
            |-> (m_tdata == FP_QNAN))
        else $error("non-canonical NaN on output");
`endif

endmodule

// ===== sv/fisr_norm.sv =====
// Two-stage normalize and round-to-nearest-even unit for binary32 results.
module fisr_norm (
    input  logic              clk,
    input  logic              en,
    input  fisr_pkg::norm_in_t in_data,
    output logic [31:0]       result
);
    import fisr_pkg::*;

    logic              sign_reg;
    kind_t             kind_reg;
    logic signed [10:0] exp_reg;
    logic [5:0]        lz_reg;
    logic [47:0]       mag_reg;
    logic [31:0]       result_reg;

    logic [5:0]        lz_next;
    kind_t             kind_next;

    // Find the leading one and flag an exact zero magnitude
    always_comb
    begin
        lz_next   = lzc48(in_data.mag);
        kind_next = in_data.kind;
        if (in_data.kind == KIND_NUM && in_data.mag == 48'd0)
        begin
            kind_next = KIND_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= in_data.sign;
            kind_reg <= kind_next;
            exp_reg  <= in_data.exp - $signed({5'd0, lz_next});
            lz_reg   <= lz_next;
            mag_reg  <= in_data.mag;
        end
    end

    logic [47:0]        shl;
    logic [47:0]        shr;
    logic signed [10:0] under;
    logic [4:0]         rsh;
    logic               lost;
    logic               tiny;
    logic [7:0]         exp_field;
    logic [23:0]        kept;
    logic               guard;
    logic               sticky;
    logic [31:0]        base;
    logic [31:0]        rounded;
    logic [31:0]        result_next;

    // Normalize, denormalize below the normal range, round, then select special values or overflow to infinity
    always_comb
    begin
        shl   = mag_reg << lz_reg;
        tiny  = (exp_reg < 11'sd1);
        under = 11'sd1 - exp_reg;
        if (!tiny)
        begin
            rsh = 5'd0;
        end
        else if (under > 11'sd25)
        begin
            rsh = 5'd25;
        end
        else
        begin
            rsh = under[4:0];
        end
        shr       = shl >> rsh;
        lost      = |(shl & ((48'd1 << rsh) - 48'd1));
        exp_field = tiny ? 8'd0 : 8'(exp_reg - 11'sd1);
        kept      = shr[47:24];
        guard     = shr[23];
        sticky    = (|shr[22:0]) | lost;
        base      = {1'b0, exp_field, 23'd0} + {8'd0, kept};
        rounded   = base + {31'd0, guard & (sticky | kept[0])};

        unique case (kind_reg)
            KIND_NAN:  result_next = FP_QNAN;
            KIND_INF:  result_next = {sign_reg, 8'hFF, 23'd0};
            KIND_ZERO: result_next = {sign_reg, 31'd0};
            default:
            begin
                if (exp_reg > 11'sd254 || rounded[30:23] == 8'hFF)
                begin
                    result_next = {sign_reg, 8'hFF, 23'd0};
                end
                else
                begin
                    result_next = {sign_reg, rounded[30:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== sv/fisr_fmul.sv =====
// Three-stage binary32 multiplier: mantissa product, then normalize and round.
module fisr_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] result
);
    import fisr_pkg::*;

    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        nan_a;
    logic        nan_b;
    logic        inf_a;
    logic        inf_b;
    logic        zero_a;
    logic        zero_b;
    kind_t       kind_next;
    logic signed [10:0] exp_next;

    norm_in_t    prod_reg;

    // Unpack operands and classify the product
    always_comb
    begin
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        exp_next = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
        begin
            kind_next = KIND_NAN;
        end
        else if (inf_a || inf_b)
        begin
            kind_next = KIND_INF;
        end
        else if (zero_a || zero_b)
        begin
            kind_next = KIND_ZERO;
        end
        else
        begin
            kind_next = KIND_NUM;
        end
    end

    // Register the full mantissa product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg.sign <= a[31] ^ b[31];
            prod_reg.kind <= kind_next;
            prod_reg.exp  <= exp_next;
            prod_reg.mag  <= ma * mb;
        end
    end

    fisr_norm u_norm (
        .clk     (clk),
        .en      (en),
        .in_data (prod_reg),
        .result  (result)
    );

endmodule

// ===== sv/fisr_fadd.sv =====
// Four-stage binary32 adder: align, add, then normalize and round.
module fisr_fadd (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] result
);
    import fisr_pkg::*;

    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  e_big;
    logic [7:0]  e_sml;
    logic [7:0]  diff;
    logic [4:0]  dsh;
    logic [27:0] m_big;
    logic [27:0] m_sml;
    logic [27:0] m_shr;
    logic        nan_a;
    logic        nan_b;
    logic        inf_a;
    logic        inf_b;
    logic        sub_op;
    kind_t       kind_next;
    logic        sign_next;

    logic [27:0] big_reg;
    logic [27:0] sml_reg;
    logic        sub_reg;
    logic        sign_reg;
    logic        zsign_reg;
    kind_t       kind_reg;
    logic signed [10:0] exp_reg;

    // Order by magnitude and align the smaller operand with sticky
    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        e_big  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff   = e_big - e_sml;
        dsh    = (diff > 8'd27) ? 5'd27 : diff[4:0];
        m_big  = {1'b0, big[30:23] != 8'd0, big[22:0], 3'd0};
        m_sml  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 3'd0};
        m_shr  = (m_sml >> dsh) | {27'd0, |(m_sml & ((28'd1 << dsh) - 28'd1))};
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        sub_op = a[31] ^ b[31];
        sign_next = big[31];
        if (nan_a || nan_b || (inf_a && inf_b && sub_op))
        begin
            kind_next = KIND_NAN;
        end
        else if (inf_a || inf_b)
        begin
            kind_next = KIND_INF;
            sign_next = inf_a ? a[31] : b[31];
        end
        else
        begin
            kind_next = KIND_NUM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg   <= m_big;
            sml_reg   <= m_shr;
            sub_reg   <= sub_op;
            sign_reg  <= sign_next;
            zsign_reg <= a[31] & b[31];
            kind_reg  <= kind_next;
            exp_reg   <= $signed({3'd0, e_big}) + 11'sd1;
        end
    end

    logic [27:0] sum;
    norm_in_t    sum_next;
    norm_in_t    sum_reg;

    // Add or subtract aligned magnitudes; exact zero takes the round-to-nearest sign
    always_comb
    begin
        sum = sub_reg ? (big_reg - sml_reg) : (big_reg + sml_reg);
        sum_next.kind = kind_reg;
        sum_next.exp  = exp_reg;
        sum_next.mag  = {sum, 20'd0};
        if (kind_reg == KIND_NUM && sum == 28'd0)
        begin
            sum_next.sign = zsign_reg;
        end
        else
        begin
            sum_next.sign = sign_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    fisr_norm u_norm (
        .clk     (clk),
        .en      (en),
        .in_data (sum_reg),
        .result  (result)
    );

endmodule
